// ===== rtl/ansi_sgr_attribute_parser_defines.svh =====
// Assertion macros for the ANSI SGR attribute parser.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ANSI_SGR_ATTRIBUTE_PARSER_DEFINES_SVH
`define ANSI_SGR_ATTRIBUTE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/asgr_pkg.sv =====
// Package for the ANSI SGR attribute parser: byte codes, parser state
// and code decode types. No dependencies.
package asgr_pkg;

    localparam logic [7:0]  C_ESC       = 8'h1B;
    localparam logic [7:0]  C_LBRACK    = 8'h5B;
    localparam logic [7:0]  C_SEMI      = 8'h3B;
    localparam logic [7:0]  C_CHAR_M    = 8'h6D;
    localparam logic [7:0]  C_DIGIT_0   = 8'h30;
    localparam logic [7:0]  C_DIGIT_9   = 8'h39;
    localparam logic [11:0] C_VALUE_MAX = 12'd4095;
    localparam logic [1:0]  C_LEN_MAX   = 2'd3;

    typedef struct packed {
        logic        esc_open;
        logic        bracket_pending;
        logic [6:0]  active_style;
        logic [8:0]  active_color;
        logic [6:0]  building_style;
        logic [8:0]  building_color;
        logic        ext_next;
        logic        prev_38;
        logic [11:0] code_value;
        logic [1:0]  code_length;
        logic        digits_only;
    } t_parse_state;

    localparam t_parse_state C_STATE_RESET = '{
        esc_open:        1'b0,
        bracket_pending: 1'b0,
        active_style:    7'd0,
        active_color:    9'd0,
        building_style:  7'd0,
        building_color:  9'd0,
        ext_next:        1'b0,
        prev_38:         1'b0,
        code_value:      12'd0,
        code_length:     2'd0,
        digits_only:     1'b1
    };

    typedef struct packed {
        logic [11:0] code_value;
        logic [1:0]  code_length;
        logic        digits_only;
        logic        ext_next;
        logic        prev_38;
        logic [6:0]  style;
        logic [8:0]  color;
    } t_code_ctx;

    typedef struct packed {
        logic [6:0] style;
        logic [8:0] color;
        logic       ext_next;
        logic       prev_38;
    } t_code_res;

endpackage

// ===== rtl/asgr_if.sv =====
// Channel interfaces of the ANSI SGR attribute parser: text byte in,
// attributed character word out. No dependencies.
interface asgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface asgr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic [6:0] style_bits;
    logic [8:0] color_id;

    modport source (output valid, output char_byte, output style_bits, output color_id,
                    input ready);
    modport sink   (input valid, input char_byte, input style_bits, input color_id,
                    output ready);
endinterface

// ===== rtl/asgr_code_decode.sv =====
// Decode of one finished SGR code into the attributes being built.
// Depends on asgr_pkg.
module asgr_code_decode (
    input  asgr_pkg::t_code_ctx i_ctx,
    output asgr_pkg::t_code_res o_res
);
    import asgr_pkg::*;

    logic [6:0] w_hit;
    logic       w_is_0;
    logic       w_is_5;
    logic       w_is_38;
    logic [7:0] w_index;

    function automatic logic text_is(input t_code_ctx c, input logic [11:0] v,
                                     input logic [1:0] len);
        return c.digits_only && (c.code_length == len) && (c.code_value == v);
    endfunction

    always_comb begin
        w_hit[0] = text_is(i_ctx, 12'd1, 2'd1);
        w_hit[1] = text_is(i_ctx, 12'd2, 2'd1);
        w_hit[2] = text_is(i_ctx, 12'd3, 2'd1);
        w_hit[3] = text_is(i_ctx, 12'd4, 2'd1);
        w_hit[4] = text_is(i_ctx, 12'd5, 2'd1);
        w_hit[5] = text_is(i_ctx, 12'd7, 2'd1);
        w_hit[6] = text_is(i_ctx, 12'd8, 2'd1);
        w_is_0   = text_is(i_ctx, 12'd0, 2'd1);
        w_is_5   = w_hit[4];
        w_is_38  = text_is(i_ctx, 12'd38, 2'd2);
        w_index  = (i_ctx.code_value > 12'd255) ? 8'hFF : i_ctx.code_value[7:0];
    end

    always_comb begin
        o_res.style    = i_ctx.style;
        o_res.color    = i_ctx.color;
        o_res.ext_next = 1'b0;
        o_res.prev_38  = 1'b0;
        if (i_ctx.ext_next) begin
            o_res.color = {1'b0, w_index} + 9'd1;
        end else begin
            if (i_ctx.prev_38 && w_is_5) begin
                o_res.ext_next = 1'b1;
            end else if (|w_hit) begin
                // at most one text code matches
                o_res.style = i_ctx.style | w_hit;
            end else if (i_ctx.code_value >= 12'd30 && i_ctx.code_value <= 12'd37) begin
                o_res.color = 9'(i_ctx.code_value - 12'd29);
            end else if (i_ctx.code_value >= 12'd90 && i_ctx.code_value <= 12'd97) begin
                o_res.color = 9'(i_ctx.code_value - 12'd81);
            end else if (w_is_0) begin
                o_res.style = 7'd0;
                o_res.color = 9'd0;
            end
            o_res.prev_38 = w_is_38;
        end
    end

endmodule

// ===== rtl/asgr_parse_core.sv =====
// Parser state registers and per-byte next-state logic.
// Depends on asgr_pkg and asgr_code_decode.
module asgr_parse_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_emit,
    output logic [6:0] o_style,
    output logic [8:0] o_color
);
    import asgr_pkg::*;

    t_parse_state r_st;
    t_parse_state n_st;
    t_code_ctx    w_ctx;
    t_code_res    w_res;
    logic         w_digit;
    logic [15:0]  w_mul;

    assign w_ctx = '{
        code_value:  r_st.code_value,
        code_length: r_st.code_length,
        digits_only: r_st.digits_only,
        ext_next:    r_st.ext_next,
        prev_38:     r_st.prev_38,
        style:       r_st.building_style,
        color:       r_st.building_color
    };

    asgr_code_decode u_decode (
        .i_ctx (w_ctx),
        .o_res (w_res)
    );

    assign w_digit = (i_byte >= C_DIGIT_0) && (i_byte <= C_DIGIT_9);
    // value * 10 + digit
    assign w_mul   = {1'b0, r_st.code_value, 3'b000} + {3'b000, r_st.code_value, 1'b0}
                   + {12'd0, 4'(i_byte - C_DIGIT_0)};

    always_comb begin
        n_st   = r_st;
        o_emit = 1'b0;
        if (r_st.bracket_pending && i_byte == C_LBRACK) begin
            n_st.bracket_pending = 1'b0;
        end else begin
            n_st.bracket_pending = 1'b0;
            if (i_byte == C_ESC) begin
                n_st.esc_open        = 1'b1;
                n_st.bracket_pending = 1'b1;
            end else if (r_st.esc_open) begin
                if (i_byte == C_CHAR_M) begin
                    n_st.active_style   = w_res.style;
                    n_st.active_color   = w_res.color;
                    n_st.building_style = 7'd0;
                    n_st.building_color = 9'd0;
                    n_st.ext_next       = 1'b0;
                    n_st.prev_38        = 1'b0;
                    n_st.esc_open       = 1'b0;
                    n_st.code_value     = 12'd0;
                    n_st.code_length    = 2'd0;
                    n_st.digits_only    = 1'b1;
                end else if (i_byte == C_SEMI) begin
                    n_st.building_style = w_res.style;
                    n_st.building_color = w_res.color;
                    n_st.ext_next       = w_res.ext_next;
                    n_st.prev_38        = w_res.prev_38;
                    n_st.code_value     = 12'd0;
                    n_st.code_length    = 2'd0;
                    n_st.digits_only    = 1'b1;
                end else begin
                    if (r_st.code_length != C_LEN_MAX) begin
                        n_st.code_length = r_st.code_length + 2'd1;
                    end
                    if (r_st.digits_only && w_digit) begin
                        n_st.code_value = (w_mul > {4'd0, C_VALUE_MAX}) ? C_VALUE_MAX
                                                                         : w_mul[11:0];
                    end else begin
                        n_st.digits_only = 1'b0;
                    end
                end
            end else begin
                o_emit = 1'b1;
            end
        end
        if (i_last) begin
            n_st = C_STATE_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_STATE_RESET;
        end else if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_style = r_st.active_style;
    assign o_color = r_st.active_color;

endmodule

// ===== rtl/ansi_sgr_attribute_parser.sv =====
// Top level of the ANSI SGR attribute parser: input word register, parse
// core and output word register. Depends on asgr_pkg, asgr_if, asgr_parse_core
// and ansi_sgr_attribute_parser_defines.svh.
//
// Usage:
//   i_in carries text bytes (data_byte) with end_of_text on the last one.
//   o_out carries one word per plain byte: char_byte with the style_bits and
//   color_id active when that byte was parsed. ESC, a '[' right after ESC,
//   escape sequence bytes and the closing 'm' give no output word.
//   Both channels move a word at a clock edge where valid and ready are high.
//   Path: a word taken into the input register is parsed when it advances out of
//   it, and o_out.valid is high once that parse has loaded the output register.
//   Throughput: one byte per clock unless a result byte waits on o_out; a single
//   pass of logic from the input register feeds the output register and state.
//   Stall: the output register frees in the cycle o_out.ready is high, so a
//   new word is taken while the last result waits. If o_out is stalled and
//   the held byte would give a result, that byte waits and i_in.ready drops.
//   Bytes that give no result pass even while o_out is stalled.
//   Reset (i_rst_n low, synchronous): both registers empty, attributes normal,
//   no sequence open. end_of_text returns the same state after its byte.
module ansi_sgr_attribute_parser (
    input logic        i_clk,
    input logic        i_rst_n,
    asgr_in_if.sink    i_in,
    asgr_out_if.source o_out
);
    import asgr_pkg::*;

`include "ansi_sgr_attribute_parser_defines.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic [6:0] r_out_style;
    logic [8:0] r_out_color;
    logic       w_adv;
    logic       w_emit;
    logic       w_in_take;
    logic [6:0] w_style;
    logic [8:0] w_color;

    asgr_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_emit  (w_emit),
        .o_style (w_style),
        .o_color (w_color)
    );

    assign w_adv     = r_in_valid && (!w_emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_char  <= r_in_byte;
            r_out_style <= w_style;
            r_out_color <= w_color;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_byte  = r_out_char;
    assign o_out.style_bits = r_out_style;
    assign o_out.color_id   = r_out_color;

    `ASGR_ASSERT_NXT(a_held_word, i_clk, i_rst_n, r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_byte), "stalled input word lost")
    `ASGR_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, w_adv && w_emit,
        r_out_valid, "parsed plain byte not presented")
    `ASGR_ASSERT_IMP(a_no_esc_out, i_clk, i_rst_n, o_out.valid,
        o_out.char_byte != C_ESC, "escape byte emitted as text")
    `ASGR_ASSERT_IMP(a_color_range, i_clk, i_rst_n, o_out.valid,
        o_out.color_id <= 9'd256, "color id out of range")

endmodule
